// File: design/tlbs_pkg.sv
package tlbs_pkg;

    localparam int TBL_DEPTH = 16;
    localparam int ENTRY_W   = 32;
    localparam int IDX_W     = $clog2(TBL_DEPTH);
    localparam int CNT_W     = $clog2(TBL_DEPTH + 1);

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int CFG_W   = 5;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LINEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BINARY = 2'd2;

    typedef logic signed [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [SLOT_W-1:0]         entry_index;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             last;
    } t_out;

    // search key travelling down the row of cells
    typedef struct packed {
        logic   vld;
        t_entry key;
    } t_probe;

    // compare result held by each cell
    typedef struct packed {
        logic eq;
        logic lt;
    } t_flag;

endpackage

// File: design/tlbs_cell.sv
module tlbs_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  tlbs_pkg::t_entry i_wr_data,
    input  tlbs_pkg::t_probe i_probe,
    output tlbs_pkg::t_probe o_probe,
    output tlbs_pkg::t_flag  o_flag
);
    import tlbs_pkg::*;

    t_entry r_entry;
    t_entry r_key;
    logic   r_vld;
    t_flag  r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_probe.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= i_probe.key;
        if (i_wr_en) begin
            r_entry <= i_wr_data;
        end
        // capture the compare as the key passes through
        if (i_probe.vld) begin
            r_flag.eq <= (r_entry == i_probe.key);
            r_flag.lt <= (r_entry < i_probe.key);
        end
    end

    assign o_probe.vld = r_vld;
    assign o_probe.key = r_key;
    assign o_flag      = r_flag;

endmodule

// File: design/table_linear_binary_search_unit.sv
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_ready     i_in_data  (command, entry_index, value)
// result    out        o_out_valid / i_out_ready   o_out_data (found, position, last)
// config    in         i_cfg_we                    i_cfg_wdata (entries_in_use)
//
// a search shifts its key down the row of 16 cells, one cell per cycle, and the compare
// phase ends when the key has passed the last cell; then a linear search walks one slot
// per cycle, holding on a hit while the output register is still full, and a binary
// search takes one probe per cycle.
// a result waits in the output register while the sequencer keeps working until it
// needs the register again. synchronous active-low reset clears control state only.
module table_linear_binary_search_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tlbs_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tlbs_pkg::t_out              o_out_data,
    input  logic                        i_cfg_we,
    input  logic [tlbs_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import tlbs_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_LIN, ST_BIN} t_state;

    t_state             r_state, n_state;
    logic               r_bin, n_bin;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic               r_out_vld, n_out_vld;
    t_out               r_out, n_out;
    logic [CFG_W-1:0]   r_entries;

    t_probe             w_probe [TBL_DEPTH+1];
    t_flag              w_flag  [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] w_hits;
    logic [TBL_DEPTH-1:0] w_eq;
    logic [TBL_DEPTH-1:0] w_lt;
    logic [TBL_DEPTH-1:0] w_wr_en;

    logic               w_accept;
    logic               w_search;
    logic               w_out_free;
    logic [CNT_W-1:0]   w_span;
    logic [CNT_W:0]     w_sum;
    logic [CNT_W-1:0]   w_mid;
    logic [CNT_W-1:0]   w_ptr_inc;
    logic               w_more;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_search   = (i_in_data.command == CMD_LINEAR) || (i_in_data.command == CMD_BINARY);

    assign w_probe[0].vld = w_accept && w_search;
    assign w_probe[0].key = i_in_data.value[ENTRY_W-1:0];

    for (genvar g = 0; g < TBL_DEPTH; g++) begin : g_cell
        assign w_wr_en[g] = w_accept && (i_in_data.command == CMD_WRITE)
                            && (32'(i_in_data.entry_index) == 32'(g));
        tlbs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (w_wr_en[g]),
            .i_wr_data(i_in_data.value[ENTRY_W-1:0]),
            .i_probe  (w_probe[g]),
            .o_probe  (w_probe[g+1]),
            .o_flag   (w_flag[g])
        );
        assign w_eq[g]   = w_flag[g].eq;
        assign w_lt[g]   = w_flag[g].lt;
        assign w_hits[g] = w_flag[g].eq && (32'(g) < 32'(w_span));
    end

    always_comb begin
        if (32'(r_entries) > TBL_DEPTH) begin
            w_span = CNT_W'(TBL_DEPTH);
        end else begin
            w_span = CNT_W'(r_entries);
        end
    end

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[CNT_W:1];
    assign w_ptr_inc  = r_ptr + CNT_W'(1);
    // any hit beyond the current slot
    assign w_more     = |(w_hits >> w_ptr_inc);
    assign w_out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_ptr     = r_ptr;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_search) begin
                    n_state = ST_WAIT;
                    n_bin   = (i_in_data.command == CMD_BINARY);
                end
            end
            ST_WAIT: begin
                // key has reached the last cell, all flags are valid
                if (w_probe[TBL_DEPTH].vld) begin
                    n_state = r_bin ? ST_BIN : ST_LIN;
                    n_ptr   = '0;
                    n_lo    = '0;
                    n_hi    = w_span;
                end
            end
            ST_LIN: begin
                if (r_ptr == w_span) begin
                    if (w_out_free) begin
                        n_out_vld = 1'b1;
                        n_out     = '{found: 1'b0, position: '0, last: 1'b1};
                        n_state   = ST_IDLE;
                    end
                end else if (w_hits[r_ptr[IDX_W-1:0]]) begin
                    if (w_out_free) begin
                        n_out_vld = 1'b1;
                        n_out     = '{found: 1'b1, position: POS_W'(w_ptr_inc),
                                     last: !w_more};
                        n_ptr     = w_ptr_inc;
                        if (!w_more) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else begin
                    n_ptr = w_ptr_inc;
                end
            end
            ST_BIN: begin
                if (r_lo < r_hi) begin
                    if (w_eq[w_mid[IDX_W-1:0]]) begin
                        if (w_out_free) begin
                            n_out_vld = 1'b1;
                            n_out     = '{found: 1'b1,
                                         position: POS_W'(w_mid + CNT_W'(1)),
                                         last: 1'b1};
                            n_state   = ST_IDLE;
                        end
                    end else if (w_lt[w_mid[IDX_W-1:0]]) begin
                        n_lo = w_mid + CNT_W'(1);
                    end else begin
                        n_hi = w_mid;
                    end
                end else if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = '{found: 1'b0, position: '0, last: 1'b1};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bin     <= 1'b0;
            r_ptr     <= '0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_out_vld <= 1'b0;
            r_entries <= '0;
        end else begin
            r_state   <= n_state;
            r_bin     <= n_bin;
            r_ptr     <= n_ptr;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.last && o_out_data.position == '0))
        else $error("not-found transfer without last or with a position");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |->
            (o_out_data.position != '0 && 32'(o_out_data.position) <= TBL_DEPTH))
        else $error("hit transfer with a position outside the table");

    a_search_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_search) |=> (r_state == ST_WAIT && !o_in_ready))
        else $error("search did not start its compare phase");

    a_no_result_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT && !o_out_valid) |=> !o_out_valid)
        else $error("result produced before the key reached the last cell");
`endif

endmodule
